// ===== design/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 32;
    localparam int PRI_W        = 16;
    localparam int CMD_W        = 2;
    localparam int ST_W         = 2;
    localparam int QDEPTH       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_SHOW = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [ST_W-1:0] ST_SHOW_EMPTY = 2'd3;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
    } op_t;

endpackage

// ===== design/spq_if.sv =====
interface spq_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic signed [31:0]              item_value;
    logic signed [15:0]              item_priority;
    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic               last;
    modport source (output valid, status, out_value, out_priority, last, input ready);
    modport sink (input valid, status, out_value, out_priority, last, output ready);
endinterface

// ===== design/spq_front.sv =====
module spq_front (
    spq_in_if.sink        in_ch,
    output logic          push,
    output spq_pkg::op_t  push_op,
    input  logic          full
);
    import spq_pkg::*;

    // drop unused command codes here; they cause no word
    assign in_ch.ready = !full;
    assign push = in_ch.valid && !full && (in_ch.command != CMD_NONE);

    always_comb
    begin
        push_op.cmd   = cmd_t'(in_ch.command);
        push_op.value = in_ch.item_value;
        push_op.prio  = in_ch.item_priority;
    end
endmodule

// ===== design/spq_fifo.sv =====
module spq_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spq_pkg::op_t  push_op,
    output logic          full,
    output logic          nempty,
    input  logic          pop,
    output spq_pkg::op_t  head_op
);
    import spq_pkg::*;

    op_t  mem_reg [QDEPTH];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'(QDEPTH));
    assign nempty  = (cnt_reg != 2'd0);
    assign head_op = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== design/spq_back.sv =====
module spq_back #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  spq_pkg::op_t  op,
    output logic          op_pop,
    spq_out_if.source     out_ch
);
    import spq_pkg::*;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [VAL_W-1:0] val_reg [CAPACITY];
    logic signed [PRI_W-1:0] pri_reg [CAPACITY];
    logic [CW-1:0] count_reg, count_next;
    logic          show_reg, show_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic              ov_reg, ov_next;
    logic [ST_W-1:0]   ost_reg, ost_next;
    logic signed [VAL_W-1:0] oval_reg, oval_next;
    logic signed [PRI_W-1:0] opri_reg, opri_next;
    logic              olast_reg, olast_next;

    logic out_free;
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] first;
    logic is_full, is_empty, do_op;

    assign out_free = !ov_reg || out_ch.ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_op    = op_valid && out_free && !show_reg;
    assign op_pop   = (do_op && !(op.cmd == CMD_SHOW && !is_empty))
                    || (show_reg && out_free && idx_reg + 1'b1 == count_reg);

    // the first cell that is vacant or holds a larger priority takes the new word; cells behind it shift
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            gt[i] = (CW'(i) >= count_reg) || (pri_reg[i] > op.prio);
        first[0] = gt[0];
        for (int i = 1; i < CAPACITY; i++)
            first[i] = gt[i] && !gt[i-1];
    end

    always_ff @(posedge clk)
    begin
        if (do_op && op.cmd == CMD_ENQ && !is_full)
        begin
            if (first[0])
            begin
                val_reg[0] <= op.value;
                pri_reg[0] <= op.prio;
            end
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (first[i])
                begin
                    val_reg[i] <= op.value;
                    pri_reg[i] <= op.prio;
                end
                else if (gt[i])
                begin
                    val_reg[i] <= val_reg[i-1];
                    pri_reg[i] <= pri_reg[i-1];
                end
            end
        end
        else if (do_op && op.cmd == CMD_DEQ && !is_empty)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                val_reg[i] <= val_reg[i+1];
                pri_reg[i] <= pri_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        show_next  = show_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ch.ready;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        opri_next  = opri_reg;
        olast_next = olast_reg;
        if (show_reg && out_free)
        begin
            ov_next    = 1'b1;
            ost_next   = ST_OK;
            oval_next  = val_reg[idx_reg[IW-1:0]];
            opri_next  = pri_reg[idx_reg[IW-1:0]];
            olast_next = (idx_reg + 1'b1 == count_reg);
            idx_next   = idx_reg + 1'b1;
            if (idx_reg + 1'b1 == count_reg)
                show_next = 1'b0;
        end
        else if (do_op)
        begin
            ov_next    = 1'b1;
            ost_next   = ST_OK;
            oval_next  = '0;
            opri_next  = '0;
            olast_next = 1'b1;
            unique case (op.cmd)
                CMD_ENQ:
                begin
                    if (is_full)
                        ost_next = ST_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                CMD_DEQ:
                begin
                    if (is_empty)
                        ost_next = ST_EMPTY;
                    else
                    begin
                        oval_next  = val_reg[0];
                        opri_next  = pri_reg[0];
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_SHOW:
                begin
                    if (is_empty)
                        ost_next = ST_SHOW_EMPTY;
                    else
                    begin
                        // hold off; the walk emits the words
                        ov_next   = 1'b0;
                        show_next = 1'b1;
                        idx_next  = '0;
                    end
                end
                default: ov_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            show_reg  <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            ost_reg   <= ST_OK;
            oval_reg  <= '0;
            opri_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            show_reg  <= show_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            ost_reg   <= ost_next;
            oval_reg  <= oval_next;
            opri_reg  <= opri_next;
            olast_reg <= olast_next;
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.status       = ost_reg;
    assign out_ch.out_value    = oval_reg;
    assign out_ch.out_priority = opri_reg;
    assign out_ch.last         = olast_reg;
endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Sorted priority queue of up to CAPACITY entries (value, signed priority).
// Input channel in_ch carries command, item_value, item_priority; output
// channel out_ch carries status, out_value, out_priority, last.
// Enqueue inserts behind all entries of lower or equal priority; dequeue
// returns the head; display emits every entry head to tail, last marked.
// Each enqueue or dequeue gives one word; display gives count words, or one
// empty status. Command code 3 is dropped with no word.
// A two-entry command queue parts the input side from the shift-register
// cell array, so input may be taken while results wait.
// A command passes the command queue register and then the output register.
// Enqueue and dequeue sustain one per cycle while out_ch takes the words; a display
// holds the cell array to start the walk and while it emits the words in turn, set by the single read port of the walk.
// Reset empties the queue and command queue; no clearing pass is needed.
// When out_ch stalls, the held word stays and the back end waits; the command
// queue then fills and in_ch.ready drops.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    spq_in_if.sink     in_ch,
    spq_out_if.source  out_ch
);
    import spq_pkg::*;

    logic push, full, nempty, pop;
    op_t  push_op, head_op;

    spq_front u_front (
        .in_ch(in_ch), .push(push), .push_op(push_op), .full(full)
    );

    spq_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op),
        .full(full), .nempty(nempty), .pop(pop), .head_op(head_op)
    );

    spq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .op_valid(nempty), .op(head_op),
        .op_pop(pop), .out_ch(out_ch)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nempty) else $error("pop from empty command queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        u_back.count_reg <= ($clog2(CAPACITY + 1))'(CAPACITY))
        else $error("entry count beyond capacity");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_value))
        else $error("result word lost under stall");
endmodule
